@@ design/sha256_block_compressor_assert.svh @@
// assertion macros used by the port checker of the sha-256 block compressor
// expects signals named clk and rst in the scope where a macro is used
`ifndef SHA256_BLOCK_COMPRESSOR_ASSERT_SVH
`define SHA256_BLOCK_COMPRESSOR_ASSERT_SVH

// condition in the same cycle
`define SBC_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sha256 block compressor port check failed");

// condition in the following cycle
`define SBC_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sha256 block compressor port check failed");

`endif

@@ design/sbc_pkg.sv @@
// shared types, constants and round functions of the sha-256 block compressor
// no dependencies
`default_nettype none

package sbc_pkg;

  localparam int unsigned WordsPerBlock = 16;
  localparam int unsigned HashWords     = 8;

  typedef logic [31:0] word_t;

  // one input request
  typedef struct packed {
    logic [31:0] msg_word;
    logic        first_block;
    logic        last_block;
  } msg_t;

  // one result request
  typedef struct packed {
    logic [31:0] hash_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_t;

  // a collected block handed from front to back
  typedef struct packed {
    word_t [WordsPerBlock-1:0] words;
    logic                      load_iv;
    logic                      iv_sel;
    logic                      last;
  } block_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROUND,
    BK_FINISH,
    BK_EMIT
  } back_state_t;

  // initial hash words, sel 0 is sha-256 and sel 1 is sha-224
  function automatic word_t iv_word(input logic sel, input logic [2:0] idx);
    word_t v;
    unique case ({sel, idx})
      4'd0:  v = 32'h6A09E667;
      4'd1:  v = 32'hBB67AE85;
      4'd2:  v = 32'h3C6EF372;
      4'd3:  v = 32'hA54FF53A;
      4'd4:  v = 32'h510E527F;
      4'd5:  v = 32'h9B05688C;
      4'd6:  v = 32'h1F83D9AB;
      4'd7:  v = 32'h5BE0CD19;
      4'd8:  v = 32'hC1059ED8;
      4'd9:  v = 32'h367CD507;
      4'd10: v = 32'h3070DD17;
      4'd11: v = 32'hF70E5939;
      4'd12: v = 32'hFFC00B31;
      4'd13: v = 32'h68581511;
      4'd14: v = 32'h64F98FA7;
      4'd15: v = 32'hBEFA4FA4;
    endcase
    return v;
  endfunction

  // round constants
  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;  6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;  6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;  6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;  6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;  6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;  6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;  6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;  6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;  6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;  6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;  6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;  6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;  6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;  6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;  6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;  6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;  6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;  6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;  6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;  6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;  6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

@@ design/sbc_front.sv @@
// front end: takes message words, collects a block and tags it with its flags
// depends on sbc_pkg
`default_nettype none

module sbc_front import sbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  msg_t   msg,
  input  logic   cfg_we,
  input  logic   cfg_data,
  output logic   q_push,
  output block_t q_block,
  input  logic   q_full
);

  logic        variant;
  logic [3:0]  word_cnt;
  logic        load_iv;
  logic        iv_sel;
  word_t       held [WordsPerBlock-1];
  logic        accept;
  logic        last_word;

  // only the closing word of a block needs room in the queue
  assign last_word = (word_cnt == 4'd15);
  assign full      = last_word && q_full;
  assign accept    = push && !full;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      variant  <= 1'b0;
      word_cnt <= 4'd0;
    end else begin
      if (cfg_we) begin
        variant <= cfg_data;
      end
      if (accept) begin
        word_cnt <= word_cnt + 4'd1;
      end
    end
  end

  // word buffer and flags sampled on the opening word
  always_ff @(posedge clk) begin
    if (accept && !last_word) begin
      held[word_cnt] <= msg.msg_word;
    end
    if (accept && word_cnt == 4'd0) begin
      load_iv <= msg.first_block;
      iv_sel  <= variant;
    end
  end

  // block handed over with the closing word
  always_comb begin
    for (int i = 0; i < WordsPerBlock - 1; i++) begin
      q_block.words[i] = held[i];
    end
    q_block.words[WordsPerBlock-1] = msg.msg_word;
    q_block.load_iv = load_iv;
    q_block.iv_sel  = iv_sel;
    q_block.last    = msg.last_block;
  end

  assign q_push = accept && last_word;

endmodule

`default_nettype wire

@@ design/sbc_block_queue.sv @@
// two-entry queue of collected blocks between front and back
// depends on sbc_pkg
`default_nettype none

module sbc_block_queue import sbc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  block_t wr_block,
  output logic   full,
  output logic   valid,
  output block_t rd_block,
  input  logic   rd_en
);

  block_t      entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_wr;
  logic        do_rd;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && valid;
  assign rd_block = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_block;
    end
  end

endmodule

`default_nettype wire

@@ design/sbc_back.sv @@
// back end: 64-round compression, chaining update and digest emission
// depends on sbc_pkg
`default_nettype none

module sbc_back import sbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  block_t  q_block,
  output logic    q_pop,
  output logic    empty,
  output digest_t digest,
  input  logic    pop
);

  back_state_t state;
  back_state_t state_next;
  logic [5:0]  rnd;
  logic [2:0]  idx;
  logic        last_blk;
  word_t       chain [HashWords];
  word_t       work  [HashWords];
  word_t       win   [WordsPerBlock];
  logic        start;
  logic        in_round;
  logic        finish;
  logic        emit_take;
  word_t       t1;
  word_t       t2;
  word_t       w_new;
  word_t       ch;
  word_t       mj;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (q_valid) state_next = BK_ROUND;
      BK_ROUND:  if (rnd == 6'd63) state_next = BK_FINISH;
      BK_FINISH: state_next = last_blk ? BK_EMIT : BK_IDLE;
      BK_EMIT:   if (pop && idx == 3'd7) state_next = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    start     = (state == BK_IDLE) && q_valid;
    in_round  = (state == BK_ROUND);
    finish    = (state == BK_FINISH);
    emit_take = (state == BK_EMIT) && pop;
    q_pop     = start;
    empty     = (state != BK_EMIT);
  end

  // round logic and message schedule
  always_comb begin
    ch    = (work[4] & (work[5] ^ work[6])) ^ work[6];
    mj    = (work[0] & (work[1] | work[2])) | (work[1] & work[2]);
    t1    = work[7] + big_sigma1(work[4]) + ch + round_k(rnd) + win[0];
    t2    = big_sigma0(work[0]) + mj;
    w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      rnd   <= 6'd0;
      idx   <= 3'd0;
    end else begin
      state <= state_next;
      if (start) begin
        rnd <= 6'd0;
      end else if (in_round) begin
        rnd <= rnd + 6'd1;
      end
      if (finish) begin
        idx <= 3'd0;
      end else if (emit_take) begin
        idx <= idx + 3'd1;
      end
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HashWords; i++) begin
        chain[i] <= iv_word(1'b0, 3'(i));
      end
    end else if (start && q_block.load_iv) begin
      for (int i = 0; i < HashWords; i++) begin
        chain[i] <= iv_word(q_block.iv_sel, 3'(i));
      end
    end else if (finish) begin
      for (int i = 0; i < HashWords; i++) begin
        chain[i] <= chain[i] + work[i];
      end
    end
  end

  // working words and schedule window
  always_ff @(posedge clk) begin
    if (start) begin
      last_blk <= q_block.last;
      for (int i = 0; i < HashWords; i++) begin
        work[i] <= q_block.load_iv ? iv_word(q_block.iv_sel, 3'(i)) : chain[i];
      end
      for (int i = 0; i < WordsPerBlock; i++) begin
        win[i] <= q_block.words[i];
      end
    end else if (in_round) begin
      work[0] <= t1 + t2;
      work[1] <= work[0];
      work[2] <= work[1];
      work[3] <= work[2];
      work[4] <= work[3] + t1;
      work[5] <= work[4];
      work[6] <= work[5];
      work[7] <= work[6];
      for (int i = 0; i < WordsPerBlock - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WordsPerBlock-1] <= w_new;
    end
  end

  // result presented straight from the chaining words
  assign digest.hash_word  = chain[idx];
  assign digest.word_index = idx;
  assign digest.final_word = (idx == 3'd7);

endmodule

`default_nettype wire

@@ design/sha256_block_compressor.sv @@
// Top level of the SHA-256 block compressor: front end, block queue and back end.
// Depends on sbc_pkg, sbc_front, sbc_block_queue and sbc_back.
// The front end takes one 32-bit word per cycle while full is low and collects
// 16 words into a block; a two-entry queue carries blocks to the back end, which
// loads each block, runs 64 rounds at one per cycle and then does one chaining
// add, so the sustained rate is set by the round loop. Full rises only on the
// sixteenth word of a block when the queue holds two blocks. After a block
// flagged last, the eight chaining words appear one per pop, word zero first;
// the back end starts no new block until the eighth word is popped, while the
// front end keeps collecting. The variant register is sampled on each block's
// first word.
`default_nettype none

module sha256_block_compressor import sbc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  msg_t    msg,
  input  logic    cfg_we,
  input  logic    cfg_data,
  output logic    empty,
  input  logic    pop,
  output digest_t digest
);

  logic   fq_push;
  block_t fq_block;
  logic   fq_full;
  logic   qb_valid;
  block_t qb_block;
  logic   qb_pop;

  // word collection
  sbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .msg      (msg),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_push   (fq_push),
    .q_block  (fq_block),
    .q_full   (fq_full)
  );

  // block handoff
  sbc_block_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fq_push),
    .wr_block (fq_block),
    .full     (fq_full),
    .valid    (qb_valid),
    .rd_block (qb_block),
    .rd_en    (qb_pop)
  );

  // compression and emission
  sbc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qb_valid),
    .q_block (qb_block),
    .q_pop   (qb_pop),
    .empty   (empty),
    .digest  (digest),
    .pop     (pop)
  );

endmodule

`default_nettype wire

@@ design/sbc_port_checker.sv @@
// port checker for the sha-256 block compressor, bound to the top level
// depends on sbc_pkg and sha256_block_compressor_assert.svh
`default_nettype none

`include "sha256_block_compressor_assert.svh"

module sbc_port_checker import sbc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input logic    pop,
  input digest_t digest
);

  // final flag marks exactly the last chaining word
  `SBC_ASSERT_IMP(a_final_index, !empty, digest.final_word == (digest.word_index == 3'd7))

  // a digest always opens with word zero
  `SBC_ASSERT_IMP(a_open_zero, $fell(empty), digest.word_index == 3'd0)

  // words follow in order without gaps
  `SBC_ASSERT_NXT(a_next_word, !empty && pop && !digest.final_word,
    !empty && digest.word_index == $past(digest.word_index) + 3'd1)

  // nothing follows the final word at once
  `SBC_ASSERT_NXT(a_final_ends, !empty && pop && digest.final_word, empty)

  // a waiting result holds
  `SBC_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(digest))

endmodule

bind sha256_block_compressor sbc_port_checker u_port_checker (.*);

`default_nettype wire
